// ===== rtl/mtd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and digit helpers for the three-digit display block
// no dependencies
package mtd_pkg;

	typedef enum logic [1:0] {
		CMD_SCAN      = 2'd0,
		CMD_MS_TICK   = 2'd1,
		CMD_SET_SLEEP = 2'd2,
		CMD_SET_TEMP  = 2'd3
	} command_t;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int HOLD_WIDTH      = 16;
	localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd3000;

	// reset target of 120, kept as decimal digits
	localparam logic [3:0] TEMP_HUND_RESET = 4'd1;
	localparam logic [3:0] TEMP_TENS_RESET = 4'd2;
	localparam logic [3:0] TEMP_ONES_RESET = 4'd0;
	// reset sleep delay of 1
	localparam logic [3:0] SLEEP_TENS_RESET = 4'd0;
	localparam logic [3:0] SLEEP_ONES_RESET = 4'd1;

	// reciprocals, exact for every 16-bit operand
	localparam logic [32:0] RECIP10   = 33'd52429;
	localparam int          SHIFT10   = 19;
	localparam logic [32:0] RECIP100  = 33'd83887;
	localparam int          SHIFT100  = 23;
	localparam logic [32:0] RECIP1000 = 33'd67109;
	localparam int          SHIFT1000 = 26;

	localparam logic [6:0] SEG_BLANK = 7'h7f;

	typedef struct packed {
		command_t    command;
		logic [15:0] value;
		logic [12:0] q10;
		logic [9:0]  q100;
		logic [6:0]  q1000;
	} split_t;

	function automatic logic [12:0] div10(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * RECIP10;
		return 13'(p >> SHIFT10);
	endfunction

	function automatic logic [9:0] div100(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * RECIP100;
		return 10'(p >> SHIFT100);
	endfunction

	function automatic logic [6:0] div1000(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * RECIP1000;
		return 7'(p >> SHIFT1000);
	endfunction

	// low digit of x given q = x / 10; only the low nibbles matter
	function automatic logic [3:0] digit_rem(input logic [3:0] x, input logic [3:0] q);
		logic [3:0] q10;
		q10 = {q[0], 3'b000} + {q[2:0], 1'b0};
		return x - q10;
	endfunction

	// lit-segment mask, F,E,D,C,B,A,G in bits 0..6
	function automatic logic [6:0] glyph(input logic [3:0] d);
		logic [6:0] m;
		unique case (d)
			4'd0: m = 7'h3f;
			4'd1: m = 7'h18;
			4'd2: m = 7'h76;
			4'd3: m = 7'h7c;
			4'd4: m = 7'h59;
			4'd5: m = 7'h6d;
			4'd6: m = 7'h6f;
			4'd7: m = 7'h38;
			4'd8: m = 7'h7f;
			4'd9: m = 7'h7d;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/muxed_three_digit_display_top.sv =====
`timescale 1ns / 1ps
// top level of the three-digit multiplexed display controller
// depends on mtd_pkg, mtd_front, mtd_core
//
// Usage: items arrive on in_valid/in_stall with command and value. Command 0
// is a scan tick and yields one result on out_valid/out_stall: active-low
// segment_lines and an active-low one-hot digit_select. Commands 1 (ms tick),
// 2 (set sleep delay) and 3 (set target temperature) yield no result.
// hold_ms is written whenever hold_ms_we is high; write it only while idle.
// A scan tick's result passes the input, quotient and output registers.
// Throughput: one item per cycle unless out_stall holds a scan result, set
// by the two-stage pipeline (input register, quotient register) feeding the
// state and output register. A stalled result holds its output register;
// later non-scan items flow until a scan item waits in the quotient register,
// so in_stall rises once both pipeline stages are full. Reset clears the
// pipeline and shows target 120, sleep delay 1, hold_ms 3000, no hold running.
module muxed_three_digit_display_top #(
	parameter int TIMER_WIDTH = mtd_pkg::TIMER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hold_ms_we,
	input  logic [mtd_pkg::HOLD_WIDTH-1:0] hold_ms,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [15:0]                   value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [6:0]                    segment_lines,
	output logic [2:0]                    digit_select
);
	import mtd_pkg::*;

	logic [HOLD_WIDTH-1:0] hold_ms_q;
	logic                  split_valid;
	logic                  split_ready;
	split_t                split;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_ms_q <= HOLD_RESET;
		else if (hold_ms_we)
			hold_ms_q <= hold_ms;
	end

	mtd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.split       (split)
	);

	mtd_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.split_valid   (split_valid),
		.split_ready   (split_ready),
		.split         (split),
		.hold_ms       (hold_ms_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.segment_lines (segment_lines),
		.digit_select  (digit_select)
	);

endmodule

// ===== rtl/mtd_front.sv =====
`timescale 1ns / 1ps
// input register and decimal quotient stage of the three-digit display
// depends on mtd_pkg
module mtd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [15:0]          value,
	output logic                 split_valid,
	input  logic                 split_ready,
	output mtd_pkg::split_t      split
);
	import mtd_pkg::*;

	logic        valid_s1;
	command_t    command_s1;
	logic [15:0] value_s1;
	logic        valid_s2;
	split_t      split_s2;
	logic        load_s2;
	logic        load_s1;
	logic [15:0] operand;

	assign load_s2  = !valid_s2 || split_ready;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// a sleep delay keeps only its low byte
	assign operand = (command_s1 == CMD_SET_SLEEP) ? {8'h00, value_s1[7:0]} : value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1 <= command_t'(command);
			value_s1   <= value;
		end
		if (load_s2 && valid_s1) begin
			split_s2.command <= command_s1;
			split_s2.value   <= operand;
			split_s2.q10     <= div10(operand);
			split_s2.q100    <= div100(operand);
			split_s2.q1000   <= div1000(operand);
		end
	end

	assign split_valid = valid_s2;
	assign split       = split_s2;

endmodule

// ===== rtl/mtd_core.sv =====
`timescale 1ns / 1ps
// display state, scan decode and output register of the three-digit display
// depends on mtd_pkg
module mtd_core #(
	parameter int TIMER_WIDTH = mtd_pkg::TIMER_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          split_valid,
	output logic                          split_ready,
	input  mtd_pkg::split_t               split,
	input  logic [mtd_pkg::HOLD_WIDTH-1:0] hold_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [6:0]                    segment_lines,
	output logic [2:0]                    digit_select
);
	import mtd_pkg::*;

	localparam int EXT_WIDTH = (TIMER_WIDTH > HOLD_WIDTH) ? TIMER_WIDTH : HOLD_WIDTH;
	localparam logic [EXT_WIDTH-1:0] TIMER_MAX = EXT_WIDTH'((64'd1 << TIMER_WIDTH) - 64'd1);

	logic [1:0]             scan_index_q;
	logic [3:0]             sleep_tens_q;
	logic [3:0]             sleep_ones_q;
	logic [3:0]             temp_hund_q;
	logic [3:0]             temp_tens_q;
	logic [3:0]             temp_ones_q;
	logic [TIMER_WIDTH-1:0] hold_remaining_q;
	logic                   first_set_seen_q;
	logic                   out_valid_q;
	logic [6:0]             seg_q;
	logic [2:0]             sel_q;

	logic                   go;
	logic                   is_scan;
	logic [1:0]             next_index;
	logic [3:0]             d_ones;
	logic [3:0]             d_tens;
	logic [3:0]             d_hund;
	logic [EXT_WIDTH-1:0]   hold_ext;
	logic [TIMER_WIDTH-1:0] hold_load;
	logic [6:0]             lit;

	assign is_scan     = (split.command == CMD_SCAN);
	assign go          = split_valid && (!is_scan || !out_valid_q || !out_stall);
	assign split_ready = !split_valid || go;

	assign next_index = (scan_index_q >= 2'd2) ? 2'd0 : scan_index_q + 2'd1;

	assign d_ones = digit_rem(split.value[3:0], split.q10[3:0]);
	assign d_tens = digit_rem(split.q10[3:0], split.q100[3:0]);
	assign d_hund = digit_rem(split.q100[3:0], split.q1000[3:0]);

	assign hold_ext  = EXT_WIDTH'(hold_ms);
	assign hold_load = (hold_ext > TIMER_MAX) ? TIMER_WIDTH'(TIMER_MAX)
	                                          : TIMER_WIDTH'(hold_ext);

	// while a hold runs: blank, then the delay in two digits
	always_comb begin
		if (hold_remaining_q != '0) begin
			unique case (next_index)
				2'd0:    lit = 7'h00;
				2'd1:    lit = glyph(sleep_tens_q);
				default: lit = glyph(sleep_ones_q);
			endcase
		end else begin
			unique case (next_index)
				2'd0:    lit = glyph(temp_hund_q);
				2'd1:    lit = glyph(temp_tens_q);
				default: lit = glyph(temp_ones_q);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_index_q     <= 2'd0;
			sleep_tens_q     <= SLEEP_TENS_RESET;
			sleep_ones_q     <= SLEEP_ONES_RESET;
			temp_hund_q      <= TEMP_HUND_RESET;
			temp_tens_q      <= TEMP_TENS_RESET;
			temp_ones_q      <= TEMP_ONES_RESET;
			hold_remaining_q <= '0;
			first_set_seen_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (go && is_scan)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (go) begin
				unique case (split.command)
					CMD_SCAN: begin
						scan_index_q <= next_index;
					end
					CMD_MS_TICK: begin
						if (hold_remaining_q != '0)
							hold_remaining_q <= hold_remaining_q - TIMER_WIDTH'(1);
					end
					CMD_SET_SLEEP: begin
						sleep_tens_q <= d_tens;
						sleep_ones_q <= d_ones;
						// the first set after reset starts no hold
						if (first_set_seen_q)
							hold_remaining_q <= hold_load;
						else
							first_set_seen_q <= 1'b1;
					end
					CMD_SET_TEMP: begin
						temp_hund_q <= d_hund;
						temp_tens_q <= d_tens;
						temp_ones_q <= d_ones;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_scan) begin
			seg_q <= ~lit;
			sel_q <= ~(3'b001 << next_index);
		end
	end

	assign out_valid     = out_valid_q;
	assign segment_lines = seg_q;
	assign digit_select  = sel_q;

`ifndef SYNTHESIS
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(~sel_q))
		else $error("digit select not one-hot low");

	a_sel_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		(go && is_scan) |=> (sel_q == ~(3'b001 << scan_index_q)))
		else $error("digit select does not follow scan index");

	a_hold_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_remaining_q != '0) |-> first_set_seen_q)
		else $error("hold running before first sleep set");

	a_tick_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(go && split.command == CMD_MS_TICK) |=> (hold_remaining_q <= $past(hold_remaining_q)))
		else $error("millisecond tick raised the hold counter");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_index_q != 2'd3)
		else $error("scan index out of range");
`endif

endmodule
